// ===== hw/rtl/mwa_pkg.sv =====
// Shared types, constants and helper functions of the masked window average block.
`default_nettype none

package mwa_pkg;

  // Raster size limits.
  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // Field widths fixed by the item format.
  localparam int IDX_W = 8;
  localparam int VALUE_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;

  // Width that holds an effective dimension and a neighbor index one past the item's index.
  localparam int ROW_DIM_W = $clog2(MAX_ROWS + 1);
  localparam int COL_DIM_W = $clog2(MAX_COLS + 1);
  localparam int DIM_W0 = (ROW_DIM_W > COL_DIM_W) ? ROW_DIM_W : COL_DIM_W;
  localparam int DIM_W = (DIM_W0 > IDX_W + 1) ? DIM_W0 : IDX_W + 1;

  // Window and accumulation widths: up to nine positive values below 2^31.
  localparam int WIN_CELLS = 9;
  localparam int STEP_W = $clog2(WIN_CELLS + 1);
  localparam int CNT_W = $clog2(WIN_CELLS + 1);
  localparam int SUM_W = VALUE_W - 1 + $clog2(WIN_CELLS);
  localparam int QUO_W = VALUE_W;

  // Divider: quotient bits retired per cycle.
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_STEPS = QUO_W / DIV_RADIX_BITS;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS);

  // Item function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

  // Reset value of both dimension registers.
  localparam logic [CFG_DATA_W-1:0] DIM_RESET = CFG_DATA_W'(256);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  // One stored cell.
  typedef struct packed {
    logic                      missing;
    logic signed [VALUE_W-1:0] value;
  } cell_t;

  // Write request to the cell store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    cell_t             entry;
  } store_wr_t;

  // Effective raster dimensions.
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } dims_t;

  // Request to the divider.
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } div_req_t;

  // Status from the divider.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_sts_t;

  // Linear store address of the cell at (r, c).
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mwa_if.sv =====
// Channel interfaces of the masked window average block: input, result and configuration.
`default_nettype none

// Input item channel.
interface mwa_in_if import mwa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [IDX_W-1:0]          row;
  logic [IDX_W-1:0]          col;
  logic signed [VALUE_W-1:0] cell_value;
  logic                      is_missing;
  logic                      include_center;

  modport source (output valid, func, row, col, cell_value, is_missing, include_center,
                  input ready);
  modport sink (input valid, func, row, col, cell_value, is_missing, include_center,
                output ready);
endinterface

// Result item channel.
interface mwa_out_if import mwa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] average;
  logic                      range_error;

  modport source (output valid, average, range_error, input ready);
  modport sink (input valid, average, range_error, output ready);
endinterface

// Configuration write channel.
interface mwa_cfg_if import mwa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/masked_window_average_core.sv =====
// Top level of the masked window average block: configuration registers and unit wiring.
//
//   Channel  Direction  Payload
//   in_ch    sink       func, row, col, cell_value, is_missing, include_center
//   out_ch   source     average, range_error
//   cfg_ch   sink       addr (0 rows_in_use, 1 cols_in_use), data
//
// A write item leaves the sequencer idle. A query holds off input until it is done: window
// reads over the store's single read port, one divider launch, the divider's iterations at
// four quotient bits each, and the handoff. A query with no counted cell skips the divider,
// and an out-of-range query goes straight to the handoff.
// A finished result waits in the output register; a further query stalls at its end
// until that register is free. Reset is synchronous and active low; it clears control
// state and sets both dimensions to 256. The store's contents are undefined until written.
`default_nettype none

module masked_window_average_core import mwa_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  mwa_in_if.sink    in_ch,
  mwa_out_if.source out_ch,
  mwa_cfg_if.sink   cfg_ch
);

  logic [CFG_DATA_W-1:0] rows_r, rows_nxt;
  logic [CFG_DATA_W-1:0] cols_r, cols_nxt;
  dims_t                 dims;
  store_wr_t             st_wr;
  logic [ADDR_W-1:0]     st_rd_addr;
  cell_t                 st_rd_data;
  div_req_t              div_req;
  div_sts_t              div_sts;

  // A zero register acts as one, a value above the limit as the limit.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v,
                                               input int lim);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > lim) begin
      res = DIM_W'(lim);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.addr)
        REG_ROWS_IN_USE: rows_nxt = cfg_ch.data;
        REG_COLS_IN_USE: cols_nxt = cfg_ch.data;
        default: begin
          rows_nxt = rows_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_RESET;
      cols_r <= DIM_RESET;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  assign dims.rows = eff_dim(rows_r, MAX_ROWS);
  assign dims.cols = eff_dim(cols_r, MAX_COLS);

  // Sequencer.
  mwa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .dims       (dims),
    .st_wr      (st_wr),
    .st_rd_addr (st_rd_addr),
    .st_rd_data (st_rd_data),
    .div_req    (div_req),
    .div_sts    (div_sts)
  );

  // Cell store.
  mwa_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // Divider.
  mwa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mwa_store.sv =====
// Cell store: one write port and one registered read port.
`default_nettype none

module mwa_store import mwa_pkg::*; (
  input  wire logic              clk,
  input  wire store_wr_t         wr,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output cell_t                  rd_data
);

  cell_t mem [STORE_DEPTH];
  cell_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mwa_div.sv =====
// Iterative divider of the window sum by the cell count, a few quotient bits per cycle.
`default_nettype none

module mwa_div import mwa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_sts_t      sts
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [QUO_W-1:0]      quo_r, quo_nxt;
  logic [CNT_W-1:0]      rem_it;
  logic [QUO_W-1:0]      quo_it;

  // Restoring division steps over the next few dividend bits; the remainder stays below the count.
  always_comb begin
    logic [CNT_W:0] part;
    rem_it = rem_r;
    quo_it = quo_r;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      part = {rem_it, quo_it[QUO_W-1]};
      quo_it = {quo_it[QUO_W-2:0], 1'b0};
      if (part >= {1'b0, cnt_r}) begin
        part = part - {1'b0, cnt_r};
        quo_it[0] = 1'b1;
      end
      rem_it = part[CNT_W-1:0];
    end
  end

  // Start, iterate and finish.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = CNT_W'(req.sum[SUM_W-1:QUO_W]);
      cnt_nxt  = req.cnt;
      quo_nxt  = req.sum[QUO_W-1:0];
    end else if (busy_r) begin
      rem_nxt  = rem_it;
      quo_nxt  = quo_it;
      step_nxt = step_r + 1'b1;
      if (step_r == DIV_STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.quot = quo_r;

`ifndef ASSERT_OFF
  // A new division never starts over one in flight.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  // Completion is a single-cycle pulse that ends the busy period.
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r ##1 !done_r)
    else $error("divider done is not a clean pulse");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mwa_ctrl.sv =====
// Sequencer: window reads, qualification and accumulation, divider control and result register.
`default_nettype none

module mwa_ctrl import mwa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  mwa_in_if.sink        in_ch,
  mwa_out_if.source     out_ch,
  input  wire dims_t    dims,
  output store_wr_t     st_wr,
  output logic [ADDR_W-1:0] st_rd_addr,
  input  wire cell_t    st_rd_data,
  output div_req_t      div_req,
  input  wire div_sts_t div_sts
);

  state_t                    state_r, state_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [IDX_W-1:0]          row_r, row_nxt;
  logic [IDX_W-1:0]          col_r, col_nxt;
  logic                      ctr_r, ctr_nxt;
  logic                      take_d_r, take_d_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [VALUE_W-1:0] res_avg_r, res_avg_nxt;
  logic                      res_err_r, res_err_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_avg_r, out_avg_nxt;
  logic                      out_err_r, out_err_nxt;

  logic             in_xfer;
  logic             in_rng_ok;
  logic             up_sel, dn_sel, lf_sel, rt_sel, ctr_sel;
  logic             nbr_ok, take_now, qual;
  logic [DIM_W-1:0] row_ext, col_ext, nrow, ncol;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign in_rng_ok = (DIM_W'(in_ch.row) < dims.rows) && (DIM_W'(in_ch.col) < dims.cols);

  // Cell writes go straight to the store in the transfer cycle.
  always_comb begin
    st_wr.en = in_xfer && (in_ch.func == FUNC_WRITE) && in_rng_ok;
    st_wr.addr = cell_addr(DIM_W'(in_ch.row), DIM_W'(in_ch.col));
    st_wr.entry.missing = in_ch.is_missing;
    st_wr.entry.value = in_ch.cell_value;
  end

  // Window position of the current step: row-major from upper left.
  always_comb begin
    up_sel  = (step_r < STEP_W'(3));
    dn_sel  = (step_r >= STEP_W'(6)) && (step_r < STEP_W'(WIN_CELLS));
    lf_sel  = (step_r == STEP_W'(0)) || (step_r == STEP_W'(3)) || (step_r == STEP_W'(6));
    rt_sel  = (step_r == STEP_W'(2)) || (step_r == STEP_W'(5)) || (step_r == STEP_W'(8));
    ctr_sel = (step_r == STEP_W'(4));
    row_ext = DIM_W'(row_r);
    col_ext = DIM_W'(col_r);
    nrow = up_sel ? row_ext - 1'b1 : (dn_sel ? row_ext + 1'b1 : row_ext);
    ncol = lf_sel ? col_ext - 1'b1 : (rt_sel ? col_ext + 1'b1 : col_ext);
    nbr_ok = (!up_sel || (row_r != '0)) &&
             (!dn_sel || (row_ext + 1'b1 < dims.rows)) &&
             (!lf_sel || (col_r != '0)) &&
             (!rt_sel || (col_ext + 1'b1 < dims.cols)) &&
             (!ctr_sel || ctr_r);
    take_now = (state_r == ST_READ) && (step_r < STEP_W'(WIN_CELLS)) && nbr_ok;
    st_rd_addr = cell_addr(nrow, ncol);
  end

  // A read cell counts when present, not missing and strictly positive.
  assign qual = take_d_r && !st_rd_data.missing && !st_rd_data.value[VALUE_W-1] &&
                (st_rd_data.value != '0);

  // Next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ctr_nxt       = ctr_r;
    take_d_nxt    = 1'b0;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    res_avg_nxt   = res_avg_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r;
    out_avg_nxt   = out_avg_r;
    out_err_nxt   = out_err_r;
    div_req.start = 1'b0;
    div_req.sum   = sum_r;
    div_req.cnt   = cnt_r;

    // The result register empties on an output transfer.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_ch.func == FUNC_QUERY)) begin
          row_nxt = in_ch.row;
          col_nxt = in_ch.col;
          ctr_nxt = in_ch.include_center;
          step_nxt = '0;
          sum_nxt = '0;
          cnt_nxt = '0;
          if (in_rng_ok) begin
            res_err_nxt = 1'b0;
            state_nxt = ST_READ;
          end else begin
            res_avg_nxt = '0;
            res_err_nxt = 1'b1;
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_READ: begin
        take_d_nxt = take_now;
        if (qual) begin
          sum_nxt = sum_r + SUM_W'(st_rd_data.value[VALUE_W-2:0]);
          cnt_nxt = cnt_r + 1'b1;
        end
        if (step_r == STEP_W'(WIN_CELLS)) begin
          state_nxt = ST_DIV_START;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DIV_START: begin
        if (cnt_r == '0) begin
          res_avg_nxt = '0;
          state_nxt = ST_FINISH;
        end else begin
          div_req.start = 1'b1;
          state_nxt = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_sts.done) begin
          res_avg_nxt = div_sts.quot;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt = res_avg_r;
          out_err_nxt = res_err_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      take_d_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      take_d_r    <= take_d_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    ctr_r     <= ctr_nxt;
    sum_r     <= sum_nxt;
    res_avg_r <= res_avg_nxt;
    res_err_r <= res_err_nxt;
    out_avg_r <= out_avg_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.average = out_avg_r;
  assign out_ch.range_error = out_err_r;

`ifndef ASSERT_OFF
  // The store is written only between queries.
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr.en |-> (state_r == ST_IDLE))
    else $error("cell write outside idle");

  // The count never exceeds the window size.
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WIN_CELLS))
    else $error("cell count above window size");

  // The divider is only ever asked to divide by a nonzero count, and only when free.
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (div_req.cnt != '0) && !div_sts.busy)
    else $error("divider started with zero count or while busy");
`endif

endmodule

`default_nettype wire

// ===== verif/masked_window_average_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of masked_window_average_core: scripted and random raster traffic.

module masked_window_average_core_tb import mwa_pkg::*;;

  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_ITEMS = 145;
  localparam int DIR_STEPS = 25;

  // One input item as it travels on the input channel.
  typedef struct packed {
    logic                      func;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [VALUE_W-1:0] cell_value;
    logic                      is_missing;
    logic                      include_center;
  } grid_item_t;

  // One window average as it travels on the result channel.
  typedef struct packed {
    logic signed [VALUE_W-1:0] average;
    logic                      range_error;
  } avg_result_t;

  typedef enum logic {STEP_ITEM, STEP_REG} step_kind_t;

  // One row of the scripted opening sequence.
  typedef struct packed {
    step_kind_t            kind;
    grid_item_t            it;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  typed;
    avg_result_t           want;
  } script_step_t;

  logic clk;
  logic rst_n;

  mwa_in_if  in_ch ();
  mwa_out_if out_ch ();
  mwa_cfg_if cfg_ch ();

  masked_window_average_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the raster: an entry exists only once the cell has been written.
  cell_t                 raster_cells [int];
  logic [CFG_DATA_W-1:0] rows_reg;
  logic [CFG_DATA_W-1:0] cols_reg;
  avg_result_t           pending_avgs [$];

  int error_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 30;
  int recv_idle_pct = 50;

  // A dimension setting of zero acts as one, and one above the limit acts as the limit.
  function automatic int effective_span(input logic [CFG_DATA_W-1:0] setting, input int limit);
    if (setting == 0) return 1;
    if (int'(setting) > limit) return limit;
    return int'(setting);
  endfunction

  // Mean of the positive, present cells of the window, truncated toward zero.
  function automatic avg_result_t predict_average(input int r, input int c, input logic ctr);
    int          nr;
    int          nc;
    int          rr;
    int          cc;
    int          hits;
    logic [35:0] total;
    cell_t       entry;
    avg_result_t res;
    nr = effective_span(rows_reg, MAX_ROWS);
    nc = effective_span(cols_reg, MAX_COLS);
    res = '0;
    total = '0;
    hits = 0;
    if (r >= nr || c >= nc) begin
      res.range_error = 1'b1;
      return res;
    end
    for (rr = r - 1; rr <= r + 1; rr++) begin
      for (cc = c - 1; cc <= c + 1; cc++) begin
        if (rr < 0 || cc < 0 || rr >= nr || cc >= nc) continue;
        if (rr == r && cc == c && !ctr) continue;
        if (!raster_cells.exists(rr * MAX_COLS + cc)) continue;
        entry = raster_cells[rr * MAX_COLS + cc];
        if (entry.missing || entry.value <= 0) continue;
        total += {4'b0, entry.value};
        hits++;
      end
    end
    if (hits > 0) res.average = VALUE_W'(total / 36'(hits));
    return res;
  endfunction

  // Updates the mirror for an accepted item and queues the average that a query owes.
  function automatic void apply_item(input grid_item_t it, input logic typed,
                                     input avg_result_t want);
    if (it.func == FUNC_WRITE) begin
      if (int'(it.row) < effective_span(rows_reg, MAX_ROWS) &&
          int'(it.col) < effective_span(cols_reg, MAX_COLS)) begin
        raster_cells[int'(it.row) * MAX_COLS + int'(it.col)] = {it.is_missing, it.cell_value};
      end
    end else begin
      pending_avgs.push_back(typed ? want : predict_average(it.row, it.col, it.include_center));
    end
  endfunction

  function automatic script_step_t write_step(input int r, input int c,
                                              input logic [VALUE_W-1:0] v, input logic m);
    script_step_t s;
    s = '0;
    s.kind = STEP_ITEM;
    s.it.func = FUNC_WRITE;
    s.it.row = IDX_W'(r);
    s.it.col = IDX_W'(c);
    s.it.cell_value = v;
    s.it.is_missing = m;
    return s;
  endfunction

  function automatic script_step_t query_step(input int r, input int c, input logic ctr);
    script_step_t s;
    s = '0;
    s.kind = STEP_ITEM;
    s.it.func = FUNC_QUERY;
    s.it.row = IDX_W'(r);
    s.it.col = IDX_W'(c);
    s.it.include_center = ctr;
    return s;
  endfunction

  function automatic script_step_t checked_query(input int r, input int c, input logic ctr,
                                                 input logic [VALUE_W-1:0] avg,
                                                 input logic err);
    script_step_t s;
    s = query_step(r, c, ctr);
    s.typed = 1'b1;
    s.want.average = avg;
    s.want.range_error = err;
    return s;
  endfunction

  function automatic script_step_t reg_step(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
    script_step_t s;
    s = '0;
    s.kind = STEP_REG;
    s.reg_idx = idx;
    s.reg_data = data;
    return s;
  endfunction

  // Opening sequence: corners, value extremes, missing and non-positive cells,
  // the center switch, dimension extremes and out-of-range accesses.
  script_step_t script [DIR_STEPS] = '{
    write_step(0, 0, 32'h7FFF_FFFF, 1'b0),
    write_step(0, 1, 32'h0000_0000, 1'b0),
    write_step(1, 0, 32'h8000_0000, 1'b0),
    write_step(1, 1, 32'h0001_0000, 1'b1),
    checked_query(0, 0, 1'b1, 32'h7FFF_FFFF, 1'b0),
    checked_query(0, 0, 1'b0, 32'h0000_0000, 1'b0),
    write_step(254, 254, 32'h7FFF_FFFF, 1'b0),
    write_step(254, 255, 32'h7FFF_FFFF, 1'b0),
    write_step(255, 254, 32'h0000_0001, 1'b0),
    write_step(255, 255, 32'hFFFF_FFFF, 1'b0),
    query_step(255, 255, 1'b1),
    query_step(255, 255, 1'b0),
    write_step(255, 255, 32'h0002_0000, 1'b1),
    query_step(255, 255, 1'b1),
    reg_step(REG_ROWS_IN_USE, 9'd2),
    reg_step(REG_COLS_IN_USE, 9'd2),
    checked_query(255, 255, 1'b1, 32'h0000_0000, 1'b1),
    checked_query(0, 255, 1'b0, 32'h0000_0000, 1'b1),
    write_step(5, 5, 32'h1234_5678, 1'b0),
    query_step(1, 1, 1'b1),
    reg_step(REG_ROWS_IN_USE, 9'd0),
    reg_step(REG_COLS_IN_USE, 9'd511),
    write_step(0, 2, 32'h0003_0000, 1'b0),
    query_step(0, 1, 1'b0),
    checked_query(1, 0, 1'b1, 32'h0000_0000, 1'b1)
  };

  // Dimension settings of the random phases; the last phase draws its own.
  logic [CFG_DATA_W-1:0] phase_rows [NUM_PHASES] = '{256, 1, 511, 3, 2, 256, 0, 40, 256};
  logic [CFG_DATA_W-1:0] phase_cols [NUM_PHASES] = '{256, 1, 3, 511, 256, 2, 0, 17, 256};

  task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("mismatch in %s at cycle %0d: got %h, expected %h", field, cycle_count, got, want);
    error_count++;
  endtask

  // Presents one item, idling first at the sender's rate, and returns after its transfer.
  // Valid stays high afterwards so that a following item can go back to back.
  task automatic push_item(input grid_item_t it, input logic typed, input avg_result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= it.func;
    in_ch.row <= it.row;
    in_ch.col <= it.col;
    in_ch.cell_value <= it.cell_value;
    in_ch.is_missing <= it.is_missing;
    in_ch.include_center <= it.include_center;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_item(it, typed, want);
    items_sent++;
  endtask

  // Drops valid, waits for every owed average and lets a trailing write finish.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dimension(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_ROWS_IN_USE) rows_reg = data;
    else cols_reg = data;
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return $urandom_range(1, 32'h00FF_FFFF);
    if (sel < 55) return $urandom_range(32'h7FFF_0000, 32'h7FFF_FFFF);
    if (sel < 65) return 32'h8000_0000 | $urandom;
    if (sel < 72) return '0;
    return $urandom;
  endfunction

  function automatic grid_item_t random_write(input int r, input int c);
    grid_item_t w;
    w.func = FUNC_WRITE;
    w.row = IDX_W'(r);
    w.col = IDX_W'(c);
    w.cell_value = random_value();
    w.is_missing = ($urandom_range(0, 4) == 0);
    w.include_center = $urandom_range(0, 1);
    return w;
  endfunction

  // Mostly near the edges and a small hot block, so that writes and queries meet.
  function automatic logic [IDX_W-1:0] pick_coord(input int dim);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return $urandom_range(0, 255);
    if (sel < 30) return $urandom_range(0, 1) ? IDX_W'(dim - 1) : '0;
    if (sel < 50) return $urandom_range(dim > 4 ? dim - 4 : 0, dim - 1);
    return $urandom_range(0, dim < 6 ? dim - 1 : 5);
  endfunction

  // Writes every in-range cell of a query window that has never been written.
  task automatic fill_window(input int r, input int c);
    int nr;
    int nc;
    int rr;
    int cc;
    nr = effective_span(rows_reg, MAX_ROWS);
    nc = effective_span(cols_reg, MAX_COLS);
    if (r >= nr || c >= nc) return;
    for (rr = r - 1; rr <= r + 1; rr++) begin
      for (cc = c - 1; cc <= c + 1; cc++) begin
        if (rr < 0 || cc < 0 || rr >= nr || cc >= nc) continue;
        if (!raster_cells.exists(rr * MAX_COLS + cc)) push_item(random_write(rr, cc), 1'b0, '0);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("masked_window_average_core_tb: errors");
    $finish;
  end

  // Result checking and random receiver stalls.
  always @(posedge clk) begin : result_check
    avg_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_avgs.size() == 0) begin
        report_mismatch("unexpected result", out_ch.average, '0);
      end else begin
        want = pending_avgs.pop_front();
        if (out_ch.average !== want.average)
          report_mismatch("average", out_ch.average, want.average);
        if (out_ch.range_error !== want.range_error)
          report_mismatch("range_error", VALUE_W'(out_ch.range_error),
                          VALUE_W'(want.range_error));
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Stimulus.
  initial begin : stimulus
    int         i;
    int         ph;
    int         target;
    int         nr;
    int         nc;
    grid_item_t it;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_WRITE;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.cell_value = '0;
    in_ch.is_missing = 1'b0;
    in_ch.include_center = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = '0;
    cfg_ch.data = '0;
    rows_reg = DIM_RESET;
    cols_reg = DIM_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Scripted opening sequence.
    for (i = 0; i < DIR_STEPS; i++) begin
      if (script[i].kind == STEP_REG) begin
        set_dimension(script[i].reg_idx, script[i].reg_data);
      end else begin
        if (script[i].it.func == FUNC_QUERY) fill_window(script[i].it.row, script[i].it.col);
        push_item(script[i].it, script[i].typed, script[i].want);
      end
    end

    // Random phases, each under its own raster size; the idling pattern changes every third phase.
    phase_rows[NUM_PHASES-1] = $urandom_range(0, 511);
    phase_cols[NUM_PHASES-1] = $urandom_range(0, 511);
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      set_dimension(REG_ROWS_IN_USE, phase_rows[ph]);
      set_dimension(REG_COLS_IN_USE, phase_cols[ph]);
      case (ph / 3)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      nr = effective_span(rows_reg, MAX_ROWS);
      nc = effective_span(cols_reg, MAX_COLS);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        it = random_write(pick_coord(nr), pick_coord(nc));
        if ($urandom_range(0, 1)) begin
          it.func = FUNC_QUERY;
          fill_window(it.row, it.col);
        end
        push_item(it, 1'b0, '0);
      end
    end

    wait_idle();
    if (error_count == 0 && pending_avgs.size() == 0) begin
      $display("masked_window_average_core_tb: clean");
    end else begin
      $display("masked_window_average_core_tb: errors");
    end
    $finish;
  end

endmodule
